>>> hdl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int IN_W   = 16;
  localparam int SQ_N   = 15;   // root bits, one per stage
  localparam int DV_N   = 16;   // quotient bits, one per stage
  localparam logic signed [17:0] Q_ONE = 18'sd16384;

  typedef struct packed {
    logic                ok;
    logic [1:0]          big;
    logic [16:0]         e;
    logic [2:0][16:0]    s;
  } fr_t;

  typedef struct packed {
    logic                ok;
    logic [1:0]          big;
    logic [29:0]         x;
    logic [16:0]         rem;
    logic [14:0]         root;
    logic [2:0][16:0]    s;
  } sq_t;

  typedef struct packed {
    logic                ok;
    logic                vz;
    logic [1:0]          big;
    logic [14:0]         v;
    logic [2:0][16:0]    s;
  } rs_t;

  typedef struct packed {
    logic                ok;
    logic                vz;
    logic [1:0]          big;
    logic [14:0]         v;
    logic [15:0]         d;
    logic [2:0]          neg;
    logic [2:0][15:0]    num;
    logic [2:0][15:0]    rem;
    logic [2:0][15:0]    q;
  } dv_t;

  function automatic sq_t sq_step(input sq_t a);
    sq_t         r;
    logic [18:0] t;
    logic [18:0] trial;
    r     = a;
    t     = {a.rem, a.x[29:28]};
    trial = {2'b00, a.root, 2'b01};
    r.x   = {a.x[27:0], 2'b00};
    if (t >= trial) begin
      r.rem  = 17'(t - trial);
      r.root = {a.root[13:0], 1'b1};
    end else begin
      r.rem  = t[16:0];
      r.root = {a.root[13:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(input dv_t a);
    dv_t         r;
    logic [16:0] t;
    r = a;
    for (int k = 0; k < 3; k++) begin
      t        = {a.rem[k], a.num[k][15]};
      r.num[k] = {a.num[k][14:0], 1'b0};
      if (t >= {1'b0, a.d}) begin
        r.rem[k] = 16'(t - {1'b0, a.d});
        r.q[k]   = {a.q[k][14:0], 1'b1};
      end else begin
        r.rem[k] = t[15:0];
        r.q[k]   = {a.q[k][14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/rotation_matrix_to_quaternion.sv
// Top level: fixed-point rotation matrix to quaternion conversion, fully pipelined.
// Converts a Q2.14 3x3 rotation matrix to a Q2.14 quaternion by Shepperd's method.
// One matrix is taken per cycle while the output is not stalled. There are 34 register
// stages: one stage forms the trace terms and picks the largest, 15 stages compute its
// rounded square root one bit each, one stage rounds, 16 stages run three restoring
// dividers one quotient bit each, and one stage saturates and orders the components.
// Any output stall freezes the whole pipe.
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // m11,m12,m13,m21,m22,m23,m31,m32,m33 (16 b each)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // quat_x,quat_y,quat_z,quat_w (16 b each)
  output logic [0:0]   m_axis_tuser    // valid_res
);
  import rmq_pkg::*;

  logic adv;
  logic vf, vr, vo;
  logic [SQ_N-1:0] vs;
  logic [DV_N-1:0] vd;
  fr_t fr, fr_next;
  sq_t sq [SQ_N];
  sq_t sq_next [SQ_N];
  rs_t rs, rs_next;
  dv_t dv [DV_N];
  dv_t dv_next [DV_N];
  logic [3:0][15:0] oq, oq_next;
  logic ook, ook_next;

  assign adv           = !vo || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = oq;
  assign m_axis_tuser  = ook;

  // front: trace terms, argmax, off-diagonal pairs
  always_comb begin
    logic signed [15:0] m [9];
    logic signed [17:0] e [4];
    logic signed [16:0] pa, pb, pc, pd, pe, pf;
    logic [1:0] big;
    for (int i = 0; i < 9; i++) m[i] = $signed(s_axis_tdata[i*IN_W +: IN_W]);
    e[0] = 18'(m[0]) - 18'(m[4]) - 18'(m[8]) + Q_ONE;
    e[1] = -18'(m[0]) + 18'(m[4]) - 18'(m[8]) + Q_ONE;
    e[2] = -18'(m[0]) - 18'(m[4]) + 18'(m[8]) + Q_ONE;
    e[3] = 18'(m[0]) + 18'(m[4]) + 18'(m[8]) + Q_ONE;
    big = 2'd0;
    for (int i = 1; i < 4; i++) if (e[i] > e[big]) big = 2'(i);
    pa = 17'(m[1]) + 17'(m[3]);
    pb = 17'(m[6]) + 17'(m[2]);
    pc = 17'(m[5]) - 17'(m[7]);
    pd = 17'(m[5]) + 17'(m[7]);
    pe = 17'(m[6]) - 17'(m[2]);
    pf = 17'(m[1]) - 17'(m[3]);
    fr_next.big = big;
    fr_next.ok  = !e[big][17];
    fr_next.e   = e[big][16:0];
    case (big)
      2'd0:    fr_next.s = {pc, pb, pa};
      2'd1:    fr_next.s = {pe, pd, pa};
      2'd2:    fr_next.s = {pf, pd, pb};
      default: fr_next.s = {pf, pe, pc};
    endcase
  end

  always_comb begin
    sq_t src;
    for (int i = 0; i < SQ_N; i++) begin
      if (i == 0) begin
        src.ok   = fr.ok;
        src.big  = fr.big;
        src.s    = fr.s;
        src.x    = fr.ok ? {1'b0, fr.e, 12'd0} : 30'd0;
        src.rem  = '0;
        src.root = '0;
      end else begin
        src = sq[i-1];
      end
      sq_next[i] = sq_step(src);
    end
  end

  // round to nearest: bump when remainder exceeds root
  always_comb begin
    rs_next.ok  = sq[SQ_N-1].ok;
    rs_next.big = sq[SQ_N-1].big;
    rs_next.s   = sq[SQ_N-1].s;
    rs_next.v   = sq[SQ_N-1].root +
                  15'({16'd0, sq[SQ_N-1].rem} > {18'd0, sq[SQ_N-1].root});
    rs_next.vz  = (sq[SQ_N-1].root == '0) && (sq[SQ_N-1].rem == '0);
  end

  always_comb begin
    dv_t src;
    logic [16:0] mag;
    logic [29:0] num;
    mag = '0;
    num = '0;
    for (int i = 0; i < DV_N; i++) begin
      if (i == 0) begin
        src.ok  = rs.ok;
        src.vz  = rs.vz;
        src.big = rs.big;
        src.v   = rs.v;
        src.d   = {rs.v, 1'b0};
        src.q   = '0;
        for (int k = 0; k < 3; k++) begin
          src.neg[k] = rs.s[k][16];
          mag        = rs.s[k][16] ? 17'(-rs.s[k]) : rs.s[k];
          num        = {mag, 13'd0} + {15'd0, rs.v};
          src.rem[k] = {2'b00, num[29:16]};
          src.num[k] = num[15:0];
        end
      end else begin
        src = dv[i-1];
      end
      dv_next[i] = dv_step(src);
    end
  end

  // saturate and place the chosen component; a rejected matrix gives all zeros
  always_comb begin
    logic [2:0][15:0] r;
    dv_t t;
    t = dv[DV_N-1];
    for (int k = 0; k < 3; k++) begin
      if (t.vz) r[k] = '0;
      else if (t.neg[k]) r[k] = (t.q[k] > 16'd32768) ? 16'h8000 : 16'(-t.q[k]);
      else r[k] = (t.q[k] > 16'd32767) ? 16'h7fff : t.q[k];
    end
    case (t.big)
      2'd0:    oq_next = {r[2], r[1], r[0], {1'b0, t.v}};
      2'd1:    oq_next = {r[2], r[1], {1'b0, t.v}, r[0]};
      2'd2:    oq_next = {r[2], {1'b0, t.v}, r[1], r[0]};
      default: oq_next = {{1'b0, t.v}, r[2], r[1], r[0]};
    endcase
    ook_next = t.ok;
    if (!t.ok) oq_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      vs <= '0;
      vr <= 1'b0;
      vd <= '0;
      vo <= 1'b0;
    end else if (adv) begin
      vf <= s_axis_tvalid;
      vs <= {vs[SQ_N-2:0], vf};
      vr <= vs[SQ_N-1];
      vd <= {vd[DV_N-2:0], vr};
      vo <= vd[DV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr <= fr_next;
      for (int i = 0; i < SQ_N; i++) sq[i] <= sq_next[i];
      rs <= rs_next;
      for (int i = 0; i < DV_N; i++) dv[i] <= dv_next[i];
      oq  <= oq_next;
      ook <= ook_next;
    end
  end

`ifndef SYNTHESIS
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    vo && !ook |-> oq == '0) else $error("rejected matrix with nonzero output");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vf) else $error("transfer lost at entry");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv[DV_N-1]) && $stable(vd)) else $error("pipe moved on stall");
  a_root_nz: assert property (@(posedge clk) disable iff (rst)
    vr && rs.ok |-> rs.v >= 15'd8192) else $error("chosen component below one half");
`endif

endmodule

>>> test/rotation_matrix_to_quaternion_tb.sv
// Testbench for the rotation matrix to quaternion pipeline: directed and random matrices.
`timescale 1ns / 100ps

class quat_scoreboard;
  logic [64:0] pending[$];
  int errors;

  function automatic longint round_sqrt(longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 << 60;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    if (x > r) r = r + 1;
    return r;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint pair_ratio(longint s, longint v);
    longint mag, q;
    if (v <= 0) return 0;
    mag = (s < 0) ? -s : s;
    q = (mag * 8192 + v) / (2 * v);
    return clip16((s < 0) ? -q : q);
  endfunction

  // returns {valid_res, w, z, y, x}
  function automatic logic [64:0] convert(logic [143:0] d);
    longint m[9];
    longint e[4];
    longint q[4];
    longint v;
    int big;
    logic [64:0] r;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
    e[0] = m[0] - m[4] - m[8] + 16384;
    e[1] = -m[0] + m[4] - m[8] + 16384;
    e[2] = -m[0] - m[4] + m[8] + 16384;
    e[3] = m[0] + m[4] + m[8] + 16384;
    big = 0;
    for (int i = 1; i < 4; i++) if (e[i] > e[big]) big = i;
    for (int i = 0; i < 4; i++) q[i] = 0;
    r[64] = 1'b1;
    if (e[big] < 0) begin
      r[64] = 1'b0;
    end else begin
      v = round_sqrt(e[big] << 12);
      q[big] = clip16(v);
      case (big)
        0: begin
          q[1] = pair_ratio(m[1] + m[3], v);
          q[2] = pair_ratio(m[6] + m[2], v);
          q[3] = pair_ratio(m[5] - m[7], v);
        end
        1: begin
          q[0] = pair_ratio(m[1] + m[3], v);
          q[2] = pair_ratio(m[5] + m[7], v);
          q[3] = pair_ratio(m[6] - m[2], v);
        end
        2: begin
          q[0] = pair_ratio(m[6] + m[2], v);
          q[1] = pair_ratio(m[5] + m[7], v);
          q[3] = pair_ratio(m[1] - m[3], v);
        end
        default: begin
          q[0] = pair_ratio(m[5] - m[7], v);
          q[1] = pair_ratio(m[6] - m[2], v);
          q[2] = pair_ratio(m[1] - m[3], v);
        end
      endcase
    end
    for (int i = 0; i < 4; i++) r[16*i +: 16] = q[i][15:0];
    return r;
  endfunction

  function void note_matrix(logic [143:0] d);
    pending.push_back(convert(d));
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_quat(logic [63:0] data, logic valid_res);
    logic [64:0] w;
    if (pending.size() == 0) begin
      $display("mismatch: output transfer with nothing pending");
      errors++;
      return;
    end
    w = pending.pop_front();
    if (data[15:0] !== w[15:0]) report("quat_x", data[15:0], w[15:0]);
    if (data[31:16] !== w[31:16]) report("quat_y", data[31:16], w[31:16]);
    if (data[47:32] !== w[47:32]) report("quat_z", data[47:32], w[47:32]);
    if (data[63:48] !== w[63:48]) report("quat_w", data[63:48], w[63:48]);
    if (valid_res !== w[64]) report("valid_res", 16'(valid_res), 16'(w[64]));
  endtask
endclass

module rotation_matrix_to_quaternion_tb;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  quat_scoreboard sb;
  logic stim_done;
  logic hold_off;
  int cycles;

  rotation_matrix_to_quaternion dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // rotation-like matrix: scaled identity permutations with signs, plus noise
  function automatic logic [143:0] rotation_like();
    logic [143:0] d;
    int p, noise;
    d = '0;
    p = $urandom_range(0, 5);
    noise = $urandom_range(0, 3) * 1024;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        int col, val;
        col = (p < 3) ? (r + p) % 3 : (p + 3 - r) % 3;
        val = (c == col) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
        if (noise > 0) val += $urandom_range(0, 2 * noise) - noise;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        d[16*(3*r + c) +: 16] = 16'(val);
      end
    end
    return d;
  endfunction

  task send_matrix(logic [143:0] d);
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_matrix(d);
    @(negedge clk);
  endtask

  task send_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task run_stimulus();
    logic [143:0] d;
    int burst;
    // identity, 180 degree turns about each axis, extremes, ties
    send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                 16'sd0, 16'sd0, 16'sd16384});
    send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                 16'sd0, 16'sd0, 16'sd16384});
    send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                 16'sd0, 16'sd0, -16'sd16384});
    send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                 16'sd0, 16'sd0, -16'sd16384});
    send_matrix('0);
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'hffff}});
    send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000, 16'h7fff, 16'h8000});
    send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 16'h7fff, 16'h8000, 16'h7fff});
    send_matrix({16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
                 16'h0000, 16'h0000, 16'h8000});
    send_matrix({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                 16'h7fff, 16'h8000, 16'h7fff});
    send_gap();
    for (int n = 0; n < RANDOM_ITEMS;) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 3) == 0)
          for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom);
        else
          d = rotation_like();
        send_matrix(d);
        n++;
      end
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    stim_done = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_stimulus();
    stim_done = 1'b1;
  end

  // receiver: random stalls, a long hold-off early so the pipe fills up
  initial begin
    int mode;
    m_axis_tready = 1'b0;
    hold_off = 1'b0;
    repeat (3) @(negedge clk);
    repeat (30) begin
      m_axis_tready <= 1'b1;
      @(negedge clk);
    end
    hold_off = 1'b1;
    m_axis_tready <= 1'b0;
    repeat (120) @(negedge clk);
    hold_off = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_quat(m_axis_tdata, m_axis_tuser[0]);
  end

  initial begin
    cycles = 0;
    @(negedge rst);
    while (!(stim_done && sb.pending.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (60) @(posedge clk);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end
endmodule
